// ----- hw/rtl/decimal_to_seven_segment_writer_defines.svh -----
// assertion macros for the decimal seven-segment writer checker
// expects clk and arst_n in the scope where a macro is used
`ifndef DECIMAL_TO_SEVEN_SEGMENT_WRITER_DEFINES_SVH
`define DECIMAL_TO_SEVEN_SEGMENT_WRITER_DEFINES_SVH

// condition that holds at every edge out of reset
`define DTSS_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that holds at the edge after the antecedent
`define DTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dtss_pkg.sv -----
// shared types, constants and glyph table for the decimal seven-segment writer
// no dependencies
`timescale 1ns / 1ps

package dtss_pkg;

	localparam int DIGITS = 8;
	localparam logic [2:0] POS_MAX = 3'(DIGITS - 1);
	localparam int DIV_W = 32;
	localparam logic [DIV_W-1:0] DIV_MAGIC = 32'hCCCC_CCCD;
	localparam int DIV_SHIFT = 35;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;
	localparam logic [7:0] SEG_POINT = 8'h80;
	localparam logic [7:0] SEL_ONE = 8'h01;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUT
	} state_t;

	typedef enum logic [1:0] {
		KIND_FRAC,
		KIND_POINT,
		KIND_INT
	} kind_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quot;
		logic [3:0] rem;
	} div_res_t;

	function automatic logic [7:0] seg_glyph(input logic [3:0] digit);
		logic [7:0] seg;
		unique case (digit)
			4'd0: seg = 8'h3F;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5B;
			4'd3: seg = 8'h4F;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6D;
			4'd6: seg = 8'h7D;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h6F;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

// ----- hw/rtl/decimal_to_seven_segment_writer.sv -----
// decimal seven-segment writer: number in, one digit write per shown digit out
// depends on dtss_pkg and dtss_div10
//
// usage:
//   s_* takes one request: s_tuser is the mode (0 integer, 1 integer.fraction),
//   s_tdata holds the integer value, fraction byte and start position.
//   m_* gives the digit writes, least significant digit first, at positions
//   counting down from the start; m_tlast marks the final write of a request.
//   a request that shows nothing gives no write at all.
// timing:
//   each digit takes one pass of the shared divide-by-ten unit (operand
//   register, then reciprocal multiply), then a sequencing step in ST_PUT
//   that loads the output register. s_tready is high only between requests.
// reset:
//   clears the sequencer and empties the output register.
// stall:
//   one write waits in the output register; while m_tready is low the
//   sequencer holds the next digit and the unit stays idle.
`timescale 1ns / 1ps

module decimal_to_seven_segment_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// integer_value[31:0], fraction_value[39:32], start_position[42:40], zero pad
	input  logic [dtss_pkg::S_DATA_W-1:0] s_tdata,
	// mode[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// digit_select[7:0], segments[15:8]
	output logic [dtss_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	dtss_pkg::state_t state_q, state_d;
	dtss_pkg::kind_t  kind_q, kind_d;
	logic [31:0] ival_q, ival_d;
	logic [7:0]  fval_q, fval_d;
	logic [2:0]  pos_q, pos_d;

	logic                          m_tvalid_q;
	logic [dtss_pkg::M_DATA_W-1:0] m_tdata_q;
	logic                          m_tlast_q;

	dtss_pkg::div_req_t div_req;
	dtss_pkg::div_res_t div_res;

	logic [31:0] in_ival;
	logic [7:0]  in_fval;
	logic [2:0]  in_pos;
	logic        out_free;
	logic        load;
	logic        load_last;
	logic        load_point;
	logic        quot_zero;

	dtss_div10 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign in_ival   = s_tdata[31:0];
	assign in_fval   = s_tdata[39:32];
	assign in_pos    = (s_tdata[42:40] > dtss_pkg::POS_MAX) ? dtss_pkg::POS_MAX
		: s_tdata[42:40];
	assign out_free  = !m_tvalid_q || m_tready;
	assign quot_zero = (div_res.quot == '0);

	always_comb begin
		state_d          = state_q;
		kind_d           = kind_q;
		ival_d           = ival_q;
		fval_d           = fval_q;
		pos_d            = pos_q;
		div_req.start    = 1'b0;
		div_req.dividend = ival_q;
		load             = 1'b0;
		load_last        = 1'b0;
		load_point       = 1'b0;
		s_tready         = (state_q == dtss_pkg::ST_IDLE);
		unique case (state_q)
			dtss_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					ival_d = in_ival;
					fval_d = in_fval;
					pos_d  = in_pos;
					if (s_tuser) begin
						div_req.start = 1'b1;
						state_d       = dtss_pkg::ST_DIV;
						if (in_fval == '0 || in_pos != '0) begin
							kind_d           = dtss_pkg::KIND_FRAC;
							div_req.dividend = {24'd0, in_fval};
						end else begin
							kind_d           = dtss_pkg::KIND_POINT;
							div_req.dividend = in_ival;
						end
					end else if (in_ival == '0 || in_pos != '0) begin
						div_req.start    = 1'b1;
						div_req.dividend = in_ival;
						kind_d           = dtss_pkg::KIND_INT;
						state_d          = dtss_pkg::ST_DIV;
					end
				end
			end
			dtss_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = dtss_pkg::ST_PUT;
				end
			end
			dtss_pkg::ST_PUT: begin
				if (out_free) begin
					load = 1'b1;
					if (kind_q == dtss_pkg::KIND_FRAC) begin
						if (fval_q == '0) begin
							load_last = (pos_q == '0);
							if (pos_q == '0) begin
								state_d = dtss_pkg::ST_IDLE;
							end else begin
								pos_d            = pos_q - 3'd1;
								kind_d           = dtss_pkg::KIND_POINT;
								div_req.start    = 1'b1;
								div_req.dividend = ival_q;
								state_d          = dtss_pkg::ST_DIV;
							end
						end else begin
							fval_d        = div_res.quot[7:0];
							pos_d         = pos_q - 3'd1;
							div_req.start = 1'b1;
							state_d       = dtss_pkg::ST_DIV;
							if (!quot_zero && pos_q > 3'd1) begin
								div_req.dividend = div_res.quot;
							end else begin
								kind_d           = dtss_pkg::KIND_POINT;
								div_req.dividend = ival_q;
							end
						end
					end else begin
						load_point = (kind_q == dtss_pkg::KIND_POINT);
						load_last  = quot_zero || pos_q <= 3'd1;
						if (load_last) begin
							state_d = dtss_pkg::ST_IDLE;
						end else begin
							ival_d           = div_res.quot;
							pos_d            = pos_q - 3'd1;
							kind_d           = dtss_pkg::KIND_INT;
							div_req.start    = 1'b1;
							div_req.dividend = div_res.quot;
							state_d          = dtss_pkg::ST_DIV;
						end
					end
				end
			end
			default: begin
				state_d = dtss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtss_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		ival_q <= ival_d;
		fval_q <= fval_d;
		pos_q  <= pos_d;
		if (load) begin
			m_tdata_q[7:0]  <= ~(dtss_pkg::SEL_ONE << pos_q);
			m_tdata_q[15:8] <= dtss_pkg::seg_glyph(div_res.rem)
				| (load_point ? dtss_pkg::SEG_POINT : 8'h00);
			m_tlast_q       <= load_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- hw/rtl/dtss_div10.sv -----
// divide-by-ten unit by reciprocal multiplication, with registered operand and quotient
// depends on dtss_pkg
`timescale 1ns / 1ps

module dtss_div10 (
	input  logic              clk,
	input  logic              arst_n,
	input  dtss_pkg::div_req_t req,
	output dtss_pkg::div_res_t res
);

	logic                         busy_q;
	logic                         done_q;
	logic [dtss_pkg::DIV_W-1:0]   dvd_q;
	logic [dtss_pkg::DIV_W-1:0]   quot_q;

	logic [2*dtss_pkg::DIV_W-1:0] prod;
	logic [3:0]                   rem;

	always_comb begin
		prod = {{dtss_pkg::DIV_W{1'b0}}, dvd_q}
			* {{dtss_pkg::DIV_W{1'b0}}, dtss_pkg::DIV_MAGIC};
		// low bits of dividend minus ten times quotient
		rem  = dvd_q[3:0] - {quot_q[2:0], 1'b0} - {quot_q[0], 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
		end
		if (busy_q) begin
			quot_q <= {{(dtss_pkg::DIV_SHIFT - dtss_pkg::DIV_W){1'b0}},
				prod[2*dtss_pkg::DIV_W-1:dtss_pkg::DIV_SHIFT]};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem;

endmodule

// ----- hw/rtl/dtss_checker.sv -----
// port-level checker for the decimal seven-segment writer, bound to the top level
// depends on dtss_pkg and decimal_to_seven_segment_writer_defines.svh
`timescale 1ns / 1ps
`include "decimal_to_seven_segment_writer_defines.svh"

module dtss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dtss_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	// stalled write holds
	`DTSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled digit write changed")

	// exactly one position selected
	`DTSS_ASSERT_HOLDS(a_one_cold, !m_tvalid || $countones(m_tdata[7:0]) == 7,
		"digit select not one-cold")

	// between requests only a final write may still wait
	`DTSS_ASSERT_HOLDS(a_idle_last, !s_tready || !m_tvalid || m_tlast,
		"ready for request with a non-final write pending")

endmodule

bind decimal_to_seven_segment_writer dtss_checker u_dtss_checker (.*);

// ----- sim/testbench.sv -----
// testbench for decimal_to_seven_segment_writer: directed and random requests with
// random stalls on both streams, each digit write checked against an in-bench predictor
// depends on dtss_pkg and the writer rtl
`timescale 1ns / 1ps

module testbench;

	localparam bit MODE_INT = 1'b0;
	localparam bit MODE_DEC = 1'b1;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 60;
	// glyphs for 9 down to 0, digit d in bits [8*d +: 8]
	localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
		8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

	typedef struct packed {
		logic       last;
		logic [7:0] seg;
		logic [7:0] sel;
	} digit_write_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	// integer_value[31:0], fraction_value[39:32], start_position[42:40], zero pad
	logic [dtss_pkg::S_DATA_W-1:0] s_tdata;
	// mode[0]
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	// digit_select[7:0], segments[15:8]
	logic [dtss_pkg::M_DATA_W-1:0] m_tdata;
	logic                          m_tlast;

	digit_write_t expected_writes[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	decimal_to_seven_segment_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void push_digit(input int pos, input int digit, input bit point);
		digit_write_t w;
		w.sel = 8'hFF & ~(8'h01 << pos);
		w.seg = GLYPHS[digit*8 +: 8] | (point ? dtss_pkg::SEG_POINT : 8'h00);
		w.last = 1'b0;
		expected_writes.push_back(w);
	endfunction

	function automatic void predict_digits(input bit mode, input logic [31:0] iv,
			input logic [7:0] fv, input logic [2:0] sp);
		int pos;
		int base;
		logic [31:0] ival;
		logic [7:0] fval;
		digit_write_t w;
		base = expected_writes.size();
		pos = int'(sp);
		if (pos > dtss_pkg::DIGITS - 1)
			pos = dtss_pkg::DIGITS - 1;
		ival = iv;
		fval = fv;
		if (mode == MODE_INT) begin
			if (ival == 0) begin
				push_digit(pos, 0, 1'b0);
			end else begin
				while (ival != 0 && pos > 0) begin
					push_digit(pos, int'(ival % 10), 1'b0);
					ival = ival / 10;
					pos--;
				end
			end
		end else begin
			if (fval == 0) begin
				push_digit(pos, 0, 1'b0);
				pos--;
			end else begin
				while (fval != 0 && pos > 0) begin
					push_digit(pos, int'(fval % 10), 1'b0);
					fval = fval / 10;
					pos--;
				end
			end
			// units digit carries the point, may sit on position 0
			if (pos >= 0) begin
				push_digit(pos, int'(ival % 10), 1'b1);
				if (ival != 0) begin
					ival = ival / 10;
					pos--;
					while (ival != 0 && pos > 0) begin
						push_digit(pos, int'(ival % 10), 1'b0);
						ival = ival / 10;
						pos--;
					end
				end
			end
		end
		if (expected_writes.size() > base) begin
			w = expected_writes.pop_back();
			w.last = 1'b1;
			expected_writes.push_back(w);
		end
	endfunction

	task automatic send_request(input bit mode, input logic [31:0] iv, input logic [7:0] fv,
			input logic [2:0] sp);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'b0, sp, fv, iv};
		do
			@(posedge clk);
		while (!s_tready);
		predict_digits(mode, iv, fv, sp);
	endtask

	task automatic wait_for_drain(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(MODE_INT, 32'd0, 8'd0, 3'd7);
		send_request(MODE_INT, 32'd0, 8'd0, 3'd0);
		send_request(MODE_INT, 32'd1, 8'd0, 3'd0);          // nothing written
		send_request(MODE_INT, 32'hFFFF_FFFF, 8'hFF, 3'd7); // digits lost
		send_request(MODE_INT, 32'd12345678, 8'd0, 3'd7);
		send_request(MODE_INT, 32'd3210, 8'd0, 3'd7);
		send_request(MODE_INT, 32'd98765, 8'd0, 3'd6);
		send_request(MODE_INT, 32'd9, 8'd0, 3'd1);
		send_request(MODE_INT, 32'd42, 8'hAA, 3'd5);        // fraction ignored
		send_request(MODE_DEC, 32'd0, 8'd0, 3'd0);          // point dropped
		send_request(MODE_DEC, 32'd0, 8'd0, 3'd1);
		send_request(MODE_DEC, 32'hFFFF_FFFF, 8'd255, 3'd7);
		send_request(MODE_DEC, 32'd6, 8'd255, 3'd2);        // point on position 0
		send_request(MODE_DEC, 32'd0, 8'd5, 3'd0);
		send_request(MODE_DEC, 32'd123, 8'd7, 3'd0);
		send_request(MODE_DEC, 32'd4000000000, 8'd0, 3'd7);
		send_request(MODE_DEC, 32'd50, 8'd19, 3'd4);
	endtask

	task automatic test_random(input int count);
		logic [31:0] iv;
		logic [7:0] fv;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: iv = $urandom;
				1: iv = $urandom_range(99999);
				2: iv = $urandom_range(9);
				default: iv = $urandom >> $urandom_range(31);
			endcase
			fv = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
			send_request(bit'($urandom_range(1)), iv, fv, 3'($urandom_range(7)));
		end
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		s_tvalid <= 1'b0;
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 8; i++)
			send_request(bit'(i % 2), $urandom, 8'($urandom_range(255)), 3'd7);
	endtask

	task automatic test_pause_until_drained();
		wait_for_drain(SETTLE_CYCLES);
		send_request(MODE_DEC, 32'd87654321, 8'd99, 3'd7);
	endtask

	// receiver side: random stalls plus one long hold-off in the backpressure test
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		digit_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_writes.size() == 0) begin
				report_error($sformatf("unexpected write sel=%h seg=%h last=%b",
					m_tdata[7:0], m_tdata[15:8], m_tlast));
			end else begin
				want = expected_writes.pop_front();
				if (m_tdata[7:0] !== want.sel)
					report_error($sformatf("digit_select got %h want %h",
						m_tdata[7:0], want.sel));
				if (m_tdata[15:8] !== want.seg)
					report_error($sformatf("segments got %h want %h",
						m_tdata[15:8], want.seg));
				if (m_tlast !== want.last)
					report_error($sformatf("last got %b want %b", m_tlast, want.last));
			end
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 72;
		test_directed();
		test_random(28);

		send_idle_pct = 72;
		recv_idle_pct = 16;
		test_random(24);
		test_backpressure();
		test_pause_until_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(22);

		wait_for_drain(SETTLE_CYCLES);
		if (expected_writes.size() != 0)
			report_error($sformatf("%0d writes never arrived", expected_writes.size()));
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
